// ----- src/angled_wheel_drive_mixer_core_macros.svh -----
// assertion macros for the angled wheel drive mixer checker
// no dependencies; included by the checker file only
`ifndef ANGLED_WHEEL_DRIVE_MIXER_CORE_MACROS_SVH
`define ANGLED_WHEEL_DRIVE_MIXER_CORE_MACROS_SVH

// implication to the next cycle, off while reset is asserted
`define AWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication to the next cycle, checked during reset as well
`define AWDM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/awdm_pkg.sv -----
// shared types and constants for the angled wheel drive mixer
// no dependencies
package awdm_pkg;

  localparam int unsigned WHEEL_SLOTS = 4;

  localparam logic [16:0] COEF_FWD = 17'd80930;
  localparam logic [16:0] COEF_YAW = 17'd82113;

  localparam logic [14:0] VELOCITY_LIMIT_RST = 15'd5120;
  localparam logic [3:0]  INVERT_MASK_RST    = 4'd0;
  localparam logic [2:0]  WHEEL_COUNT_RST    = 3'd4;

  // per slot sign pattern: lateral subtracted, yaw added
  localparam logic [WHEEL_SLOTS-1:0] LAT_NEG = 4'b1010;
  localparam logic [WHEEL_SLOTS-1:0] YAW_POS = 4'b1100;

  typedef enum logic [1:0] {
    REG_VELOCITY_LIMIT = 2'd0,
    REG_INVERT_MASK    = 2'd1,
    REG_WHEEL_COUNT    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_VELOCITY = 1'b0,
    OP_AXIS     = 1'b1
  } op_t;

  typedef struct packed {
    logic              op;
    logic signed [15:0] forward_velocity;
    logic signed [15:0] lateral_velocity;
    logic signed [15:0] yaw_rate;
    logic [1:0]        axis_slot;
    logic              axis_fault;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        wheel_slot;
    logic signed [15:0] wheel_speed;
    logic              last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [14:0] velocity_limit;
    logic [3:0]  invert_mask;
    logic [2:0]  wheel_count;
  } cfg_t;

  typedef struct packed {
    logic signed [33:0] fwd;
    logic signed [33:0] yaw;
    logic signed [31:0] lat;
    logic [2:0]         count;
  } prod_t;

endpackage

// ----- src/awdm_front.sv -----
// input register, axis ready tracking and coefficient products
// depends on awdm_pkg
module awdm_front import awdm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     prod_valid,
  input  logic     prod_ready,
  output prod_t    prod
);

  logic                   s1_v_r;
  logic                   s1_v_nxt;
  in_word_t               s1_r;
  logic [WHEEL_SLOTS-1:0] ready_bits_r;
  logic [WHEEL_SLOTS-1:0] ready_bits_nxt;
  logic                   s2_v_r;
  logic                   s2_v_nxt;
  prod_t                  s2_r;
  prod_t                  s2_nxt;

  logic [2:0]             n_eff;
  logic [WHEEL_SLOTS-1:0] need;
  logic                   slots_ready;
  logic                   s2_free;
  logic                   s1_adv;
  logic                   s2_load;
  logic signed [17:0]     kf;
  logic signed [17:0]     ky;

  assign kf = {1'b0, COEF_FWD};
  assign ky = {1'b0, COEF_YAW};

  always_comb begin
    n_eff = (cfg.wheel_count > 3'(WHEEL_SLOTS)) ? 3'(WHEEL_SLOTS) : cfg.wheel_count;
    case (n_eff)
      3'd1:    need = 4'b0001;
      3'd2:    need = 4'b0011;
      3'd3:    need = 4'b0111;
      3'd4:    need = 4'b1111;
      default: need = 4'b0000;
    endcase
    slots_ready = (n_eff != 3'd0) && ((ready_bits_r & need) == need);
  end

  assign s2_free  = !s2_v_r || prod_ready;
  assign s1_adv   = s1_v_r && ((s1_r.op == OP_AXIS) || !slots_ready || s2_free);
  assign s2_load  = s1_adv && (s1_r.op == OP_VELOCITY) && slots_ready;
  assign in_ready = !s1_v_r || s1_adv;

  always_comb begin
    s1_v_nxt = in_ready ? in_valid : s1_v_r;
    ready_bits_nxt = ready_bits_r;
    if (s1_adv && (s1_r.op == OP_AXIS) && ({1'b0, s1_r.axis_slot} < n_eff)) begin
      ready_bits_nxt[s1_r.axis_slot] = !s1_r.axis_fault;
    end
    s2_nxt.fwd   = 34'(kf * s1_r.forward_velocity);
    s2_nxt.yaw   = 34'(ky * s1_r.yaw_rate);
    s2_nxt.lat   = {s1_r.lateral_velocity, 16'd0};
    s2_nxt.count = n_eff;
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (prod_ready) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      ready_bits_r <= '0;
    end else begin
      s1_v_r       <= s1_v_nxt;
      s2_v_r       <= s2_v_nxt;
      ready_bits_r <= ready_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_r <= in_data;
    end
    if (s2_load) begin
      s2_r <= s2_nxt;
    end
  end

  assign prod_valid = s2_v_r;
  assign prod       = s2_r;

endmodule

// ----- src/awdm_mix.sv -----
// wheel sums, rounding, saturation, inversion and result sequencing
// depends on awdm_pkg
module awdm_mix import awdm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      prod_valid,
  output logic      prod_ready,
  input  prod_t     prod,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic               v_r;
  logic               v_nxt;
  logic [1:0]         idx_r;
  logic [1:0]         idx_nxt;
  logic [2:0]         cnt_r;
  logic signed [15:0] spd_r   [WHEEL_SLOTS];
  logic signed [15:0] spd_nxt [WHEEL_SLOTS];

  logic               last;
  logic               emit;
  logic               load;
  logic signed [34:0] sum [WHEEL_SLOTS];
  logic signed [18:0] rnd [WHEEL_SLOTS];
  logic signed [18:0] lim;
  logic signed [18:0] sat [WHEEL_SLOTS];

  assign last       = (3'({1'b0, idx_r} + 3'd1) == cnt_r);
  assign emit       = v_r && out_ready;
  assign prod_ready = !v_r || (out_ready && last);
  assign load       = prod_valid && prod_ready;
  assign lim        = {4'd0, cfg.velocity_limit};

  always_comb begin
    for (int i = 0; i < WHEEL_SLOTS; i++) begin
      sum[i] = 35'(prod.fwd) + 35'sd32768;
      if (LAT_NEG[2'(i)]) begin
        sum[i] = sum[i] - 35'(prod.lat);
      end else begin
        sum[i] = sum[i] + 35'(prod.lat);
      end
      if (YAW_POS[2'(i)]) begin
        sum[i] = sum[i] + 35'(prod.yaw);
      end else begin
        sum[i] = sum[i] - 35'(prod.yaw);
      end
      rnd[i] = sum[i][34:16];
      if (rnd[i] > lim) begin
        sat[i] = lim;
      end else if (rnd[i] < -lim) begin
        sat[i] = -lim;
      end else begin
        sat[i] = rnd[i];
      end
      if (cfg.invert_mask[2'(i)]) begin
        spd_nxt[i] = 16'(-sat[i]);
      end else begin
        spd_nxt[i] = 16'(sat[i]);
      end
    end
  end

  always_comb begin
    v_nxt   = v_r;
    idx_nxt = idx_r;
    if (load) begin
      v_nxt   = 1'b1;
      idx_nxt = 2'd0;
    end else if (emit && last) begin
      v_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      v_r   <= v_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r <= prod.count;
      for (int i = 0; i < WHEEL_SLOTS; i++) begin
        spd_r[i] <= spd_nxt[i];
      end
    end
  end

  assign out_valid            = v_r;
  assign out_data.wheel_slot  = idx_r;
  assign out_data.wheel_speed = spd_r[idx_r];
  assign out_data.last_of_run = last;

endmodule

// ----- src/angled_wheel_drive_mixer_core.sv -----
// top level of the angled wheel drive mixer: config registers and the two stages
// depends on awdm_pkg, awdm_front and awdm_mix
//
// input channel in_valid/in_ready/in_data carries velocity commands (op 0) and
// axis responses (op 1). axis responses set or clear a slot ready bit and give
// no result. a velocity command, when every configured slot is ready, gives one
// word per configured wheel on out_valid/out_ready/out_data in slot order
// 0..3, with last_of_run on the final one; otherwise it gives nothing.
// path: after acceptance a command passes the input register, the product
// register and then the speed buffer, where its first word is offered.
// throughput: one word per cycle at the output while out_ready is high, and a
// command holds the speed buffer until its wheel_count words (4 by default)
// have gone; axis responses go at one per cycle. the next command is multiplied while the current words drain.
// configuration: cfg_we/cfg_addr/cfg_wdata, no read back.
// reset (synchronous, rst_n low): limit 5120, invert mask 0, wheel count 4,
// all ready bits cleared, pipeline empty.
// when out_ready is low the current word holds and the stages behind fill up,
// then in_ready drops.
module angled_wheel_drive_mixer_core import awdm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_VELOCITY_LIMIT: cfg_nxt.velocity_limit = cfg_wdata;
        REG_INVERT_MASK:    cfg_nxt.invert_mask    = cfg_wdata[3:0];
        REG_WHEEL_COUNT:    cfg_nxt.wheel_count    = cfg_wdata[2:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.velocity_limit <= VELOCITY_LIMIT_RST;
      cfg_r.invert_mask    <= INVERT_MASK_RST;
      cfg_r.wheel_count    <= WHEEL_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  awdm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  awdm_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- src/awdm_checker.sv -----
// port level checks for the angled wheel drive mixer, bound to the top level
// depends on awdm_pkg and angled_wheel_drive_mixer_core_macros.svh
`include "angled_wheel_drive_mixer_core_macros.svh"

module awdm_checker import awdm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `AWDM_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "output valid right after reset")
  `AWDM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled word changed")
  `AWDM_ASSERT_NEXT(a_slot_step, clk, rst_n, out_valid && out_ready && !out_data.last_of_run, out_valid && (out_data.wheel_slot == 2'($past(out_data.wheel_slot) + 2'd1)), "wheel slot did not advance within a run")
  `AWDM_ASSERT_NEXT(a_run_restart, clk, rst_n, out_valid && out_ready && out_data.last_of_run, !out_valid || (out_data.wheel_slot == 2'd0), "new run does not start at slot zero")

endmodule

bind angled_wheel_drive_mixer_core awdm_checker u_awdm_checker (.*);
